// ===== hdl/tamu_pkg.sv =====
// Shared types and constants of the typed atomic memory unit.
// Depends on nothing; imported by the core, the checker and the testbench.
`default_nettype none

package tamu_pkg;

  // Width of the address and bound arithmetic, wide enough for the largest memory.
  localparam int unsigned ChkW = 21;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ELEM_TYPE   = 2'd0;
  localparam logic [1:0] CFG_ELEM_COUNT  = 2'd1;
  localparam logic [1:0] CFG_VIEW_OFFSET = 2'd2;

  // Operation codes.
  typedef enum logic [3:0] {
    OP_LOAD     = 4'd0,
    OP_STORE    = 4'd1,
    OP_ADD      = 4'd2,
    OP_SUB      = 4'd3,
    OP_AND      = 4'd4,
    OP_OR       = 4'd5,
    OP_XOR      = 4'd6,
    OP_EXCHANGE = 4'd7,
    OP_CMPXCHG  = 4'd8
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BOUNDS = 2'd2
  } status_e;

  // Element size selector: log2 of the size in bytes.
  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2,
    SZ_64 = 2'd3
  } size_e;

  // Control states, one-hot.
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/typed_atomic_memory_unit_core.sv =====
// Typed atomic memory unit: request decode, word memory and read-modify-write datapath.
// Depends on tamu_pkg.
`default_nettype none
// An accepted request and its word are registered; in the execute state the result is
// registered and the word written back, waiting while an earlier result still waits on
// the result channel. A new request is taken only in the idle state, after the last one
// has finished, as the single-port word memory is read in the accept cycle.
// Reset sets control state and configuration, then a clearing pass zeroes the memory
// one 64-bit word per cycle, all ceil(MEM_BYTES / 8) words, with in_ready_o low.

module typed_atomic_memory_unit_core #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [11:0] elem_index_i,
  input  wire logic [63:0] operand_bits_i,
  input  wire logic [63:0] expected_bits_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      old_value_o,
  output logic [1:0]       status_o
);
  import tamu_pkg::*;

  localparam int unsigned Words = (MEM_BYTES + 7) / 8;
  localparam int unsigned Waw   = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [ChkW-1:0] MemLimit = ChkW'(MEM_BYTES);
  localparam logic [Waw-1:0]  LastWord = Waw'(Words - 1);

  // Configuration registers.
  logic [2:0]  elem_type_q;
  logic [12:0] elem_count_q;
  logic [11:0] view_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_type_q  <= 3'd4;
      elem_count_q <= 13'd0;
      view_off_q   <= 12'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ELEM_TYPE:   elem_type_q  <= cfg_data_i[2:0];
        CFG_ELEM_COUNT:  elem_count_q <= cfg_data_i;
        CFG_VIEW_OFFSET: view_off_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Element geometry from the type register.
  size_e       size_sel;
  logic        elem_signed;
  logic [63:0] elem_mask;
  logic        misaligned;

  assign size_sel    = size_e'(elem_type_q[2:1]);
  assign elem_signed = ~elem_type_q[0];

  always_comb begin
    unique case (size_sel)
      SZ_8: begin
        elem_mask  = 64'h0000_0000_0000_00FF;
        misaligned = 1'b0;
      end
      SZ_16: begin
        elem_mask  = 64'h0000_0000_0000_FFFF;
        misaligned = view_off_q[0];
      end
      SZ_32: begin
        elem_mask  = 64'h0000_0000_FFFF_FFFF;
        misaligned = |view_off_q[1:0];
      end
      default: begin
        elem_mask  = 64'hFFFF_FFFF_FFFF_FFFF;
        misaligned = |view_off_q[2:0];
      end
    endcase
  end

  // View bound, index check and byte address of the request.
  logic [ChkW-1:0] view_end;
  logic [ChkW-1:0] byte_addr;
  status_e         req_status;

  assign view_end  = ChkW'(view_off_q) + (ChkW'(elem_count_q) << size_sel);
  assign byte_addr = ChkW'(view_off_q) + (ChkW'(elem_index_i) << size_sel);

  always_comb begin
    if (misaligned || (view_end > MemLimit)) begin
      req_status = ST_BOUNDS;
    end else if ({1'b0, elem_index_i} >= elem_count_q) begin
      req_status = ST_RANGE;
    end else begin
      req_status = ST_OK;
    end
  end

  // Control state.
  state_e         state_q, state_d;
  logic [Waw-1:0] clr_cnt_q;
  logic           out_valid_q;
  logic           accept;
  logic           finish;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == LastWord) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (finish) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Request registers held while the word is read and modified.
  op_e            op_q;
  logic [63:0]    operand_q;
  logic [63:0]    expected_q;
  logic [2:0]     lane_q;
  logic [Waw-1:0] word_q;
  status_e        req_status_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= op_e'(op_i);
      operand_q    <= operand_bits_i;
      expected_q   <= expected_bits_i;
      lane_q       <= byte_addr[2:0];
      word_q       <= byte_addr[3 +: Waw];
      req_status_q <= req_status;
    end
  end

  // Word memory with registered read data.
  logic [63:0]    mem [Words];
  logic [63:0]    rd_q;
  logic           wr_en;
  logic [Waw-1:0] wr_addr;
  logic [63:0]    wr_data;
  logic [7:0]     wr_be;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[byte_addr[3 +: Waw]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int b = 0; b < 8; b++) begin
        if (wr_be[b]) begin
          mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
        end
      end
    end
  end

  // Modify step: extract the element, apply the operation, place it back in its lanes.
  logic [63:0] raw;
  logic [63:0] raw_ext;
  logic [63:0] new_val;
  logic [63:0] result;
  logic        do_write;
  logic [7:0]  size_be;

  assign raw = (rd_q >> {lane_q, 3'b000}) & elem_mask;

  always_comb begin
    unique case (size_sel)
      SZ_8:    raw_ext = elem_signed ? {{56{raw[7]}},  raw[7:0]}  : raw;
      SZ_16:   raw_ext = elem_signed ? {{48{raw[15]}}, raw[15:0]} : raw;
      SZ_32:   raw_ext = elem_signed ? {{32{raw[31]}}, raw[31:0]} : raw;
      default: raw_ext = raw;
    endcase
  end

  always_comb begin
    new_val  = raw;
    result   = raw_ext;
    do_write = 1'b1;
    case (op_q)
      OP_STORE: begin
        new_val = operand_q;
        result  = operand_q;
      end
      OP_ADD:      new_val = raw + operand_q;
      OP_SUB:      new_val = raw - operand_q;
      OP_AND:      new_val = raw & operand_q;
      OP_OR:       new_val = raw | operand_q;
      OP_XOR:      new_val = raw ^ operand_q;
      OP_EXCHANGE: new_val = operand_q;
      OP_CMPXCHG: begin
        if (raw == (expected_q & elem_mask)) begin
          new_val = operand_q;
        end else begin
          do_write = 1'b0;
        end
      end
      default: do_write = 1'b0;
    endcase
  end

  always_comb begin
    unique case (size_sel)
      SZ_8:    size_be = 8'h01;
      SZ_16:   size_be = 8'h03;
      SZ_32:   size_be = 8'h0F;
      default: size_be = 8'hFF;
    endcase
  end

  // Memory write: zero words during the clearing pass, else the modified element.
  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
      wr_be   = 8'hFF;
    end else begin
      wr_en   = finish && do_write && (req_status_q == ST_OK);
      wr_addr = word_q;
      wr_data = (new_val & elem_mask) << {lane_q, 3'b000};
      wr_be   = size_be << lane_q;
    end
  end

  // Output register.
  logic [63:0] old_value_q;
  status_e     status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      old_value_q <= (req_status_q == ST_OK) ? result : 64'd0;
      status_q    <= req_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign old_value_o = old_value_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== test/typed_atomic_memory_unit_checker.sv =====
// Result checker for the typed atomic memory unit: watches the configuration port and the
// request and result channels, keeps its own copy of memory and view registers, and compares each result.
// Depends on tamu_pkg for register indexes, operation codes and status codes.

module typed_atomic_memory_unit_checker #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [3:0]  op_i,
  input  logic [11:0] elem_index_i,
  input  logic [63:0] operand_bits_i,
  input  logic [63:0] expected_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] old_value_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import tamu_pkg::*;

  typedef struct packed {
    logic [63:0] old_value;
    status_e     status;
  } access_result_t;

  logic [7:0]     mem_model [MEM_BYTES];
  logic [2:0]     elem_type;
  logic [12:0]    elem_count;
  logic [11:0]    view_offset;
  access_result_t result_q [$];
  access_result_t want;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Applies one atomic access to the memory copy and returns the result it yields.
  function automatic access_result_t apply_access(input logic [3:0] op, input logic [11:0] idx,
                                                  input logic [63:0] opnd,
                                                  input logic [63:0] expv);
    access_result_t res;
    int unsigned    nbytes;
    int unsigned    nbits;
    int unsigned    base;
    logic [63:0]    mask;
    logic [63:0]    raw;
    logic [63:0]    nv;
    logic [63:0]    sign_bit;
    logic           write_back;
    nbytes = 1 << elem_type[2:1];
    nbits = nbytes * 8;
    mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    res.old_value = '0;
    res.status = ST_OK;
    // The view itself is checked before the index.
    if ((view_offset % nbytes) != 0 || int'(view_offset) + int'(elem_count) * nbytes > MEM_BYTES)
    begin
      res.status = ST_BOUNDS;
      return res;
    end
    if (idx >= elem_count) begin
      res.status = ST_RANGE;
      return res;
    end
    base = view_offset + idx * nbytes;
    raw = '0;
    for (int k = 0; k < nbytes; k++) begin
      raw |= 64'(mem_model[base + k]) << (8 * k);
    end
    // Signed types have an even type code.
    if (!elem_type[0] && nbits < 64) begin
      sign_bit = 64'd1 << (nbits - 1);
      res.old_value = (raw ^ sign_bit) - sign_bit;
    end else begin
      res.old_value = raw;
    end
    nv = raw;
    write_back = 1'b1;
    case (op)
      OP_STORE: begin
        nv = opnd;
        res.old_value = opnd;
      end
      OP_ADD:      nv = raw + opnd;
      OP_SUB:      nv = raw - opnd;
      OP_AND:      nv = raw & opnd;
      OP_OR:       nv = raw | opnd;
      OP_XOR:      nv = raw ^ opnd;
      OP_EXCHANGE: nv = opnd;
      OP_CMPXCHG: begin
        if (raw == (expv & mask)) nv = opnd;
        else write_back = 1'b0;
      end
      default:     write_back = 1'b0;
    endcase
    if (write_back) begin
      nv &= mask;
      for (int k = 0; k < nbytes; k++) begin
        mem_model[base + k] = nv[8 * k +: 8];
      end
    end
    return res;
  endfunction

  // Sample all channels at the rising edge; results are matched before new requests are added.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mem_model[a]) mem_model[a] = 8'h00;
      elem_type = 3'd4;
      elem_count = '0;
      view_offset = '0;
      result_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result old_value=%h status=%0d with no request pending",
                                    old_value_i, status_i));
        end else begin
          want = result_q.pop_front();
          checked_o++;
          if (status_i !== want.status) begin
            report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                      checked_o, status_i, want.status));
          end
          if (old_value_i !== want.old_value) begin
            report_mismatch($sformatf("result %0d old_value %h, predicted %h",
                                      checked_o, old_value_i, want.old_value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.insert(result_q.size(),
                        apply_access(op_i, elem_index_i, operand_bits_i, expected_bits_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ELEM_TYPE:   elem_type = cfg_data_i[2:0];
          CFG_ELEM_COUNT:  elem_count = cfg_data_i;
          CFG_VIEW_OFFSET: view_offset = cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
    pending_o = result_q.size();
  end

endmodule

// ===== test/typed_atomic_memory_unit_core_tb.sv =====
// Testbench top for typed_atomic_memory_unit_core: clock, reset, view settings, request
// stimulus and result back-pressure. Depends on tamu_pkg and typed_atomic_memory_unit_checker.

module typed_atomic_memory_unit_core_tb;
  import tamu_pkg::*;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned CALM_PHASE  = 3;
  localparam int unsigned HOLD_PHASE  = 7;

  // Element type codes of the element_type register.
  localparam logic [2:0] TYPE_INT8   = 3'd0;
  localparam logic [2:0] TYPE_UINT8  = 3'd1;
  localparam logic [2:0] TYPE_INT16  = 3'd2;
  localparam logic [2:0] TYPE_UINT16 = 3'd3;
  localparam logic [2:0] TYPE_INT32  = 3'd4;
  localparam logic [2:0] TYPE_UINT32 = 3'd5;
  localparam logic [2:0] TYPE_INT64  = 3'd6;
  localparam logic [2:0] TYPE_UINT64 = 3'd7;

  // Unused operation codes, which behave as loads.
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  op_i;
  logic [11:0] elem_index_i;
  logic [63:0] operand_bits_i;
  logic [63:0] expected_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] old_value_o;
  logic [1:0]  status_o;

  int          fail_count;
  int          pending;
  int          checked;

  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned hold_left = 0;
  int unsigned requests_sent = 0;
  int unsigned views_used = 0;
  logic [2:0]  cur_type;
  int unsigned cur_count;
  logic [11:0] last_index = '0;

  typed_atomic_memory_unit_core #(
    .MEM_BYTES(MEM_BYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .elem_index_i   (elem_index_i),
    .operand_bits_i (operand_bits_i),
    .expected_bits_i(expected_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .old_value_o    (old_value_o),
    .status_o       (status_o)
  );

  typed_atomic_memory_unit_checker #(
    .MEM_BYTES(MEM_BYTES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .op_i           (op_i),
    .elem_index_i   (elem_index_i),
    .operand_bits_i (operand_bits_i),
    .expected_bits_i(expected_bits_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .old_value_i    (old_value_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready_i <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one request and waits until the block takes it.
  task automatic send_request(input logic [3:0] op, input logic [11:0] idx,
                              input logic [63:0] opnd, input logic [63:0] expv);
    @(negedge clk_i);
    if (sender_idles) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    elem_index_i    <= idx;
    operand_bits_i  <= opnd;
    expected_bits_i <= expv;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    last_index = idx;
  endtask

  // Stops offering requests and waits until every predicted result has been returned.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Writes all three view registers on consecutive cycles while the block is idle.
  task automatic switch_view(input logic [2:0] etype, input int unsigned count,
                             input int unsigned offset);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ELEM_TYPE;
    cfg_data_i <= 13'(etype);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ELEM_COUNT;
    cfg_data_i <= 13'(count);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_VIEW_OFFSET;
    cfg_data_i <= 13'(offset);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_type  = etype;
    cur_count = count;
    views_used++;
  endtask

  // Picks a view: mostly small, valid windows so that elements are hit again and again.
  task automatic pick_view();
    logic [2:0]  etype;
    int unsigned nbytes;
    int unsigned count;
    int unsigned offset;
    int unsigned sel;
    etype  = 3'($urandom_range(TYPE_UINT64));
    nbytes = 1 << etype[2:1];
    sel    = $urandom_range(9);
    if (sel == 0) begin
      // Broken view: misaligned where possible, otherwise running past the end.
      if (nbytes > 1) begin
        count  = $urandom_range(8);
        offset = $urandom_range(64) * nbytes + $urandom_range(nbytes - 1, 1);
      end else begin
        count  = $urandom_range(8191, MEM_BYTES + 1);
        offset = $urandom_range(MEM_BYTES - 1);
      end
    end else if (sel == 1) begin
      count  = 0;
      offset = $urandom_range(MEM_BYTES / nbytes - 1) * nbytes;
    end else if (sel == 2) begin
      count  = MEM_BYTES / nbytes;
      offset = 0;
    end else begin
      count  = $urandom_range(32, 1);
      offset = $urandom_range((MEM_BYTES - count * nbytes) / nbytes) * nbytes;
    end
    switch_view(etype, count, offset);
  endtask

  // One random request, biased toward repeated elements and values that make
  // compare-exchange succeed.
  task automatic send_random_request();
    logic [3:0]  op;
    logic [11:0] idx;
    logic [63:0] opnd;
    logic [63:0] expv;
    int unsigned nbits;
    int unsigned live;
    int unsigned r;
    nbits = 8 << cur_type[2:1];
    live  = (cur_count > MEM_BYTES) ? MEM_BYTES : cur_count;
    op = ($urandom_range(99) < 92) ? 4'($urandom_range(OP_CMPXCHG))
                                   : 4'($urandom_range(OP_SPARE_HI));
    r = $urandom_range(99);
    if (r < 55 && live > 0) idx = 12'($urandom_range(live - 1));
    else if (r < 82) idx = last_index;
    else if (r < 92) idx = 12'(cur_count + $urandom_range(1));
    else idx = 12'($urandom);
    r = $urandom_range(9);
    if (r < 4) opnd = 64'($urandom_range(3));
    else if (r == 4) opnd = '1;
    else if (r == 5) opnd = 64'd1 << (nbits - 1);
    else opnd = rand64();
    if ($urandom_range(1) == 1) begin
      expv = 64'($urandom_range(3));
      if (nbits < 64 && $urandom_range(1) == 1) expv |= rand64() << nbits;
    end else begin
      expv = rand64();
    end
    send_request(op, idx, opnd, expv);
  endtask

  initial begin
    int unsigned items;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ELEM_TYPE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    op_i            = OP_LOAD;
    elem_index_i    = '0;
    operand_bits_i  = '0;
    expected_bits_i = '0;
    cur_type        = TYPE_INT32;
    cur_count       = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // The block zeroes its memory after reset before it takes requests.
    while (!in_ready_o) @(negedge clk_i);

    // Reset view has no elements: every index is out of range.
    send_request(OP_LOAD, 12'd0, '0, '0);
    send_request(OP_STORE, 12'hFFF, '1, '0);

    // Signed bytes: every operation, wrap-around and sign extension.
    switch_view(TYPE_INT8, 16, 0);
    send_request(OP_STORE, 12'd0, '1, '0);
    send_request(OP_LOAD, 12'd0, '0, '0);
    send_request(OP_ADD, 12'd0, 64'd1, '0);
    send_request(OP_SUB, 12'd1, 64'd1, '0);
    send_request(OP_AND, 12'd1, 64'h0F, '0);
    send_request(OP_OR, 12'd2, 64'h80, '0);
    send_request(OP_XOR, 12'd2, 64'hFF, '0);
    send_request(OP_EXCHANGE, 12'd3, 64'h1234_5678_9ABC_DEF0, '0);
    // Compare-exchange: truncated match replaces, mismatch leaves the element alone.
    send_request(OP_CMPXCHG, 12'd3, 64'h55, 64'hFFFF_FFFF_FFFF_FFF0);
    send_request(OP_CMPXCHG, 12'd3, 64'h66, 64'h54);
    send_request(OP_SPARE_LO, 12'd3, '1, '1);
    send_request(OP_SPARE_HI, 12'd15, '1, '1);
    send_request(OP_LOAD, 12'd16, '0, '0);
    send_request(OP_LOAD, 12'hFFF, '0, '0);

    // Last byte of memory as an unsigned view.
    switch_view(TYPE_UINT8, 1, MEM_BYTES - 1);
    send_request(OP_STORE, 12'd0, 64'hFFFF_FFFF_FFFF_FFAB, '0);
    send_request(OP_LOAD, 12'd0, '0, '0);

    // Whole memory as 64-bit words, then one element too many.
    switch_view(TYPE_UINT64, MEM_BYTES / 8, 0);
    send_request(OP_STORE, 12'd511, '1, '0);
    send_request(OP_LOAD, 12'd511, '0, '0);
    send_request(OP_SUB, 12'd0, 64'd1, '0);
    switch_view(TYPE_UINT64, MEM_BYTES / 8 + 1, 0);
    send_request(OP_LOAD, 12'd0, '0, '0);
    switch_view(TYPE_INT16, 8191, 0);
    send_request(OP_LOAD, 12'd0, '0, '0);
    // Misaligned view, then an aligned but empty one.
    switch_view(TYPE_INT32, 4, 2);
    send_request(OP_ADD, 12'd1, 64'd1, '0);
    switch_view(TYPE_INT16, 0, MEM_BYTES - 2);
    send_request(OP_LOAD, 12'd0, '0, '0);

    // Random phases, each on a fresh view.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      pick_view();
      sender_idles   = (phase != CALM_PHASE && phase != HOLD_PHASE);
      receiver_idles = (phase != CALM_PHASE);
      if (phase == HOLD_PHASE) hold_left = HOLD_CYCLES;
      items = (phase == CALM_PHASE) ? 300 : 112;
      for (int unsigned n = 0; n < items; n++) send_random_request();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests over %0d views of all eight element types, with stalls,",
             requests_sent, views_used);
    $display("a long result hold-off and an idle-free stretch; %0d results compared.",
             checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tamu_pkg.sv
hdl/typed_atomic_memory_unit_core.sv
test/typed_atomic_memory_unit_checker.sv
test/typed_atomic_memory_unit_core_tb.sv
